// ===== design/pcd_pkg.sv =====
// Package with shared types, constants and a helper function of the prefix-code decoder.
`default_nettype none
package pcd_pkg;

	localparam int unsigned MAX_ENTRIES_DEF  = 256;
	localparam int unsigned MAX_CODE_LEN_DEF = 32;
	localparam int unsigned BITS_PER_BYTE    = 8;
	localparam int unsigned CODE_W           = 32;
	localparam int unsigned LEN_W            = 6;
	localparam int unsigned SYM_W            = 8;
	localparam int unsigned LIMIT_W          = 48;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_DATA  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_SCAN,
		ST_LOAD_WR,
		ST_BIT_RES,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             ovf;
		logic             lim;
	} result_t;

	// Mask that keeps the low len bits of a code word.
	function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] m;
		if (len >= LEN_W'(CODE_W)) begin
			m = '1;
		end else begin
			m = (CODE_W'(1) << len) - CODE_W'(1);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== design/prefix_code_bit_decoder.sv =====
// Top level of the table-driven prefix-code decoder with its control sequencer.
// Per bit: a shift state, a serial scan of the table entries below the count (none when the
// table is empty) and a result state, which stalls while a new result meets a full output.
// One transaction at a time, set by the serial scan of the one read port; start, unknown and
// ignored load commands end in idle, and loads scan the table before the write state. Reset
// clears control, counters and bit_limit; only table entries below the count are ever read.
`default_nettype none
module prefix_code_bit_decoder #(
	parameter int unsigned MAX_ENTRIES  = pcd_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned MAX_CODE_LEN = pcd_pkg::MAX_CODE_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // byte_value[7:0], code_length[13:8], code_value[45:14]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // symbol[7:0]
	output logic             m_tlast,
	output logic [1:0]       m_tuser,  // overflow_error[0], limit_reached[1]
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned LEN_CAP = (MAX_CODE_LEN < pcd_pkg::CODE_W) ?
		MAX_CODE_LEN : pcd_pkg::CODE_W;
	localparam int unsigned LW = pcd_pkg::LEN_W;
	localparam int unsigned KW = pcd_pkg::CODE_W;

	// Configuration register: bit_limit is the only register, at address zero.
	logic [pcd_pkg::LIMIT_W-1:0] bit_limit_q;

	assign pready = 1'b1;
	assign prdata = {{(64 - pcd_pkg::LIMIT_W){1'b0}}, bit_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_limit_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == 4'd0)) begin
			bit_limit_q <= pwdata[pcd_pkg::LIMIT_W-1:0];
		end
	end

	// Stream state.
	pcd_pkg::state_t state_q, state_d;
	logic [CW-1:0]               count_q;
	logic [KW-1:0]               pend_code_q;
	logic [LW-1:0]               pend_len_q;
	logic [pcd_pkg::LIMIT_W-1:0] consumed_q;

	// Working registers of the transaction in progress.
	logic [7:0]     byte_q;
	logic [2:0]     bit_q;
	logic [KW-1:0]  cand_code_q;
	logic [LW-1:0]  cand_len_q;
	logic [CW-1:0]  scan_q;
	logic           hit_q;
	logic [AW-1:0]  hit_idx_q;
	logic [7:0]     hit_sym_q;

	// A result is held back one step so that the last one of a byte can carry tlast.
	logic              held_valid_q;
	pcd_pkg::result_t  held_q;
	logic              m_valid_q;
	pcd_pkg::result_t  m_res_q;
	logic              m_last_q;

	// Memory read pipeline.
	logic             rd_valid_s1;
	logic [AW-1:0]    rd_idx_s1;
	pcd_pkg::entry_t  rd_entry;
	logic             rd_en;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	pcd_pkg::entry_t  wr_entry;

	logic accept;
	logic out_free;
	logic push_out;
	logic can_issue;
	logic match;
	logic scan_done;
	logic res_gen;
	logic limit_hit;
	logic cur_bit;
	logic load_ok;
	pcd_pkg::cmd_t   in_cmd;
	logic [LW-1:0]   in_len;
	pcd_pkg::result_t new_res;

	assign in_cmd   = pcd_pkg::cmd_t'(s_tuser);
	assign in_len   = s_tdata[13:8];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign can_issue = (scan_q < count_q) && !match;
	assign match    = rd_valid_s1 && (rd_entry.len == cand_len_q) &&
		(rd_entry.code == cand_code_q);
	assign scan_done = match || (!rd_valid_s1 && (scan_q >= count_q));
	assign limit_hit = consumed_q >= bit_limit_q;
	assign cur_bit   = byte_q[bit_q];
	assign load_ok   = (in_len != '0) && (in_len <= LW'(LEN_CAP));
	assign res_gen   = hit_q || (cand_len_q >= LW'(LEN_CAP));
	assign rd_en     = (state_q == pcd_pkg::ST_SCAN) && can_issue;

	// The held result moves to the output register when a newer one replaces it or at flush.
	assign push_out  = held_valid_q && out_free &&
		(((state_q == pcd_pkg::ST_BIT_RES) && res_gen) || (state_q == pcd_pkg::ST_FLUSH));

	always_comb begin
		new_res.sym = hit_q ? hit_sym_q : 8'd0;
		new_res.ovf = !hit_q;
		new_res.lim = limit_hit;
	end

	// Next state.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			pcd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_cmd == pcd_pkg::CMD_LOAD && load_ok) begin
						state_d = pcd_pkg::ST_SCAN;
					end else if (in_cmd == pcd_pkg::CMD_DATA) begin
						state_d = pcd_pkg::ST_BIT;
					end
				end
			end
			pcd_pkg::ST_BIT: begin
				state_d = limit_hit ? pcd_pkg::ST_FLUSH : pcd_pkg::ST_SCAN;
			end
			pcd_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = pcd_pkg::ST_BIT_RES;
				end
			end
			pcd_pkg::ST_LOAD_WR: begin
				state_d = pcd_pkg::ST_IDLE;
			end
			pcd_pkg::ST_BIT_RES: begin
				if (!(res_gen && held_valid_q && !out_free)) begin
					state_d = (bit_q == 3'd0) ? pcd_pkg::ST_FLUSH : pcd_pkg::ST_BIT;
				end
			end
			pcd_pkg::ST_FLUSH: begin
				if (!held_valid_q || out_free) begin
					state_d = pcd_pkg::ST_IDLE;
				end
			end
			default: state_d = pcd_pkg::ST_IDLE;
		endcase
	end

	// A scan that began from a load finishes in the write state instead.
	logic is_load_q;
	pcd_pkg::state_t state_n;
	always_comb begin
		state_n = state_d;
		if (state_q == pcd_pkg::ST_SCAN && scan_done && is_load_q) begin
			state_n = pcd_pkg::ST_LOAD_WR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Table writes happen only after the scan, so reads and writes never overlap.
	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = hit_idx_q;
		wr_entry.sym   = byte_q;
		wr_entry.len   = cand_len_q;
		wr_entry.code  = cand_code_q;
		if (state_q == pcd_pkg::ST_LOAD_WR) begin
			if (hit_q) begin
				wr_en = 1'b1;
			end else if (count_q < CW'(MAX_ENTRIES)) begin
				wr_en   = 1'b1;
				wr_addr = count_q[AW-1:0];
			end
		end
	end

	pcd_table #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (scan_q[AW-1:0]),
		.rd_entry (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pend_code_q  <= '0;
			pend_len_q   <= '0;
			consumed_q   <= '0;
			rd_valid_s1  <= 1'b0;
			held_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
			is_load_q    <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (push_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				pcd_pkg::ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							pcd_pkg::CMD_START: begin
								count_q     <= '0;
								pend_code_q <= '0;
								pend_len_q  <= '0;
								consumed_q  <= '0;
							end
							pcd_pkg::CMD_LOAD: begin
								is_load_q <= 1'b1;
								hit_q     <= 1'b0;
							end
							pcd_pkg::CMD_DATA: begin
								is_load_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				pcd_pkg::ST_BIT: begin
					hit_q <= 1'b0;
					if (!limit_hit) begin
						consumed_q <= consumed_q + 1'b1;
					end
				end
				pcd_pkg::ST_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
					end
				end
				pcd_pkg::ST_LOAD_WR: begin
					if (!hit_q && count_q < CW'(MAX_ENTRIES)) begin
						count_q <= count_q + 1'b1;
					end
				end
				pcd_pkg::ST_BIT_RES: begin
					if (res_gen) begin
						if (!(held_valid_q && !out_free)) begin
							held_valid_q <= 1'b1;
							pend_code_q  <= '0;
							pend_len_q   <= '0;
						end
					end else begin
						pend_code_q <= cand_code_q;
						pend_len_q  <= cand_len_q;
					end
				end
				pcd_pkg::ST_FLUSH: begin
					if (held_valid_q && out_free) begin
						held_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[AW-1:0];
		unique case (state_q)
			pcd_pkg::ST_IDLE: begin
				if (accept) begin
					byte_q      <= s_tdata[7:0];
					bit_q       <= 3'd7;
					cand_len_q  <= in_len;
					cand_code_q <= s_tdata[45:14] & pcd_pkg::len_mask(in_len);
					scan_q      <= '0;
				end
			end
			pcd_pkg::ST_BIT: begin
				cand_code_q <= {pend_code_q[KW-2:0], cur_bit};
				cand_len_q  <= pend_len_q + 1'b1;
				scan_q      <= '0;
			end
			pcd_pkg::ST_SCAN: begin
				if (can_issue) begin
					scan_q <= scan_q + 1'b1;
				end
				if (match) begin
					hit_idx_q <= rd_idx_s1;
					hit_sym_q <= rd_entry.sym;
				end
			end
			pcd_pkg::ST_BIT_RES: begin
				if (res_gen && !(held_valid_q && !out_free)) begin
					if (held_valid_q) begin
						m_res_q  <= held_q;
						m_last_q <= 1'b0;
					end
					held_q <= new_res;
				end
				if (!(res_gen && held_valid_q && !out_free)) begin
					bit_q <= bit_q - 1'b1;
				end
			end
			pcd_pkg::ST_FLUSH: begin
				if (held_valid_q && out_free) begin
					m_res_q  <= held_q;
					m_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_res_q.sym;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_res_q.lim, m_res_q.ovf};

`ifndef NO_ASSERTIONS
	// Every held result has been flushed before the next transaction is taken.
	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !held_valid_q)
		else $error("held result left behind at idle");

	// The table never grows past its capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	// Memory read data only arrives while the scan runs.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == pcd_pkg::ST_SCAN))
		else $error("table read outside scan");

	// The partial code never reaches the length cap between bytes.
	a_pend_len: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (pend_len_q < LW'(LEN_CAP)))
		else $error("partial code too long");
`endif

endmodule
`default_nettype wire

// ===== design/pcd_table.sv =====
// Code table memory: one write port and one read port with registered read data.
`default_nettype none
module pcd_table #(
	parameter int unsigned MAX_ENTRIES = pcd_pkg::MAX_ENTRIES_DEF,
	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  wire logic           clk,
	input  wire logic           wr_en,
	input  wire logic [AW-1:0]  wr_addr,
	input  wire pcd_pkg::entry_t wr_entry,
	input  wire logic           rd_en,
	input  wire logic [AW-1:0]  rd_addr,
	output pcd_pkg::entry_t     rd_entry
);

	pcd_pkg::entry_t mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== verif/prefix_code_bit_decoder_chk.sv =====
// Checker that predicts and compares the decoded symbol stream of the prefix-code decoder.
module prefix_code_bit_decoder_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
		logic       ovf;
		logic       lim;
	} sym_out_t;

	logic [7:0]  tab_sym  [256];
	logic [5:0]  tab_len  [256];
	logic [31:0] tab_code [256];
	int          tab_cnt;
	logic [31:0] acc_code;
	int          acc_len;
	logic [47:0] bits_used;
	logic [47:0] limit;
	sym_out_t    sym_q[$];

	assign pending = sym_q.size();

	function automatic int lookup(int len, logic [31:0] code);
		for (int k = 0; k < tab_cnt; k++)
			if (tab_len[k] == len && tab_code[k] == code) return k;
		return -1;
	endfunction

	function automatic logic [31:0] mask_of(int len);
		return (len >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
	endfunction

	task automatic decode_item(pcd_pkg::cmd_t cmd, logic [47:0] d);
		logic [7:0]  bv;
		logic [5:0]  ln;
		logic [31:0] cv;
		int          hit;
		int          first;
		sym_out_t    r;
		bv = d[7:0];
		ln = d[13:8];
		cv = d[45:14];
		first = sym_q.size();
		case (cmd)
			pcd_pkg::CMD_START: begin
				tab_cnt = 0; acc_code = 0; acc_len = 0; bits_used = 0;
			end
			pcd_pkg::CMD_LOAD: begin
				if (ln != 0 && ln <= 32) begin
					cv &= mask_of(ln);
					hit = lookup(ln, cv);
					if (hit >= 0) tab_sym[hit] = bv;
					else if (tab_cnt < 256) begin
						tab_sym[tab_cnt] = bv; tab_len[tab_cnt] = ln;
						tab_code[tab_cnt] = cv; tab_cnt++;
					end
				end
			end
			pcd_pkg::CMD_DATA: begin
				for (int b = 7; b >= 0; b--) begin
					if (bits_used >= limit) break;
					acc_code = {acc_code[30:0], bv[b]};
					acc_len++;
					bits_used++;
					hit = lookup(acc_len, acc_code & mask_of(acc_len));
					if (hit >= 0 || acc_len >= 32) begin
						r.sym  = (hit >= 0) ? tab_sym[hit] : 8'd0;
						r.last = 1'b0;
						r.ovf  = (hit < 0);
						r.lim  = (bits_used >= limit);
						sym_q.push_back(r);
						acc_code = 0; acc_len = 0;
					end
				end
				if (sym_q.size() > first) sym_q[sym_q.size()-1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		sym_out_t got, want;
		if (!arst_n) begin
			errors = 0; tab_cnt = 0; acc_code = 0; acc_len = 0;
			bits_used = 0; limit = 0; sym_q.delete();
		end else begin
			if (psel && penable && pwrite && paddr == 4'd0)
				limit = pwdata[47:0];
			// Results are compared before the new transaction adds expectations.
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
				if (sym_q.size() == 0) begin
					$display("%0t: expected no result, got %h", $time, got);
					errors++;
				end else begin
					want = sym_q.pop_front();
					if (got !== want) begin
						$display("%0t: expected sym %h last %b ovf %b lim %b, got %h %b %b %b",
							$time, want.sym, want.last, want.ovf, want.lim,
							got.sym, got.last, got.ovf, got.lim);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) decode_item(pcd_pkg::cmd_t'(s_tuser), s_tdata);
		end
	end
endmodule

// ===== verif/prefix_code_bit_decoder_tb.sv =====
// Testbench top that drives commands and configuration into the prefix-code decoder.
module prefix_code_bit_decoder_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // byte_value, code_length, code_value from the low bit up
	logic [1:0]  s_tuser = '0;  // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // symbol
	logic        m_tlast;
	logic [1:0]  m_tuser;       // overflow_error, limit_reached
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	int          errors, pending;

	// Live code set: the loader keeps these so random data mostly decodes.
	logic [7:0]  c_sym[16];
	logic [5:0]  c_len[16];
	logic [31:0] c_code[16];

	localparam logic [3:0] REG_BIT_LIMIT = 4'd0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	prefix_code_bit_decoder uut (.*);

	prefix_code_bit_decoder_chk chk (.*);

	// The receiver stalls on its own pattern: long ready stretches, then random runs.
	always @(posedge clk) begin
		int phase;
		phase = int'(($time / 4) % 400);
		m_tready <= (phase < 100) ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	// One transaction on the input stream; a random gap sometimes follows it.
	task automatic send(pcd_pkg::cmd_t cmd, logic [7:0] bv, logic [5:0] ln, logic [31:0] cv);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, cv, ln, bv};
		do @(posedge clk); while (!s_tready);
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Waits for every expected symbol, then lets an in-flight scan finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8 * 300) @(posedge clk);
	endtask

	task automatic write_limit(logic [47:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= REG_BIT_LIMIT; pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// A fresh code set by canonical counting, lengths up to 4, random symbols; not always prefix-free.
	task automatic load_code_set(int n);
		logic [31:0] next;
		int          l;
		send(pcd_pkg::CMD_START, 8'($urandom), 6'($urandom), $urandom);
		next = 0; l = 1;
		for (int k = 0; k < n; k++) begin
			if (k == n - 1 || $urandom_range(0, 1)) begin
				c_len[k] = 6'(l);
			end else begin
				l++; next = next << 1; c_len[k] = 6'(l);
			end
			if (l > 4) begin l = 4; c_len[k] = 6'd4; end
			c_code[k] = next; c_sym[k] = 8'($urandom);
			// Junk above the length must be masked off.
			send(pcd_pkg::CMD_LOAD, c_sym[k], c_len[k], c_code[k] | ($urandom << c_len[k]));
			next++;
		end
	endtask

	initial begin
		logic [7:0] bv;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A zero limit decodes nothing.
		send(pcd_pkg::CMD_START, 8'h00, 6'd0, 32'd0);
		send(pcd_pkg::CMD_LOAD, 8'hAA, 6'd1, 32'd0);
		send(pcd_pkg::CMD_DATA, 8'h00, 6'd0, 32'd0);
		drain();
		write_limit(48'hFFFF_FFFF_FFFF);
		send(pcd_pkg::CMD_LOAD, 8'h55, 6'd1, 32'hFFFF_FFFF);   // code 1 after masking
		send(pcd_pkg::CMD_LOAD, 8'h11, 6'd1, 32'd0);           // replaces the symbol of code 0
		send(pcd_pkg::CMD_LOAD, 8'hFF, 6'd0, 32'd5);           // zero length is ignored
		send(pcd_pkg::CMD_LOAD, 8'hFF, 6'd33, 32'd5);          // too long, ignored
		send(pcd_pkg::CMD_LOAD, 8'hFF, 6'd63, 32'd5);
		send(pcd_pkg::CMD_NONE, 8'hFF, 6'h3F, 32'hFFFF_FFFF);  // unknown command
		send(pcd_pkg::CMD_DATA, 8'hA5, 6'h3F, 32'hFFFF_FFFF);
		send(pcd_pkg::CMD_DATA, 8'hFF, 6'd0, 32'd0);
		// Only a full-length code: the bytes of ones decode it, the zero bytes overflow.
		send(pcd_pkg::CMD_START, 8'h00, 6'd0, 32'd0);
		send(pcd_pkg::CMD_LOAD, 8'h7E, 6'd32, 32'hFFFF_FFFF);
		for (int k = 0; k < 4; k++) send(pcd_pkg::CMD_DATA, 8'hFF, 6'd0, 32'd0);
		for (int k = 0; k < 4; k++) send(pcd_pkg::CMD_DATA, 8'h00, 6'd0, 32'd0);
		drain();
		// Limit ends mid-byte.
		write_limit(48'd5);
		send(pcd_pkg::CMD_START, 8'h00, 6'd0, 32'd0);
		send(pcd_pkg::CMD_LOAD, 8'h01, 6'd1, 32'd1);
		send(pcd_pkg::CMD_LOAD, 8'h02, 6'd2, 32'd0);
		send(pcd_pkg::CMD_DATA, 8'hB4, 6'd0, 32'd0);
		send(pcd_pkg::CMD_DATA, 8'hFF, 6'd0, 32'd0);
		drain();

		// Random part in phases with varying limits; one phase with a larger table.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				3:       write_limit(48'd1);
				6:       write_limit(48'($urandom_range(40, 200)));
				default: write_limit(48'hFFFF_FFFF_FFFF);
			endcase
			if (ph == 8) begin
				// A table of distinct 9-bit codes.
				send(pcd_pkg::CMD_START, 8'h00, 6'd0, 32'd0);
				for (int k = 0; k < 20; k++)
					send(pcd_pkg::CMD_LOAD, 8'($urandom), 6'd9, 32'(k));
				for (int k = 0; k < 4; k++)
					send(pcd_pkg::CMD_DATA, 8'($urandom), 6'd0, 32'd0);
			end else begin
				load_code_set($urandom_range(2, 12));
				for (int k = 0; k < 20; k++) begin
					if ($urandom_range(0, 9) == 0)
						send(pcd_pkg::cmd_t'($urandom_range(1, 3)), 8'($urandom),
							6'($urandom), $urandom);
					else begin
						bv = 8'($urandom);
						send(pcd_pkg::CMD_DATA, bv, 6'($urandom), $urandom);
					end
				end
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("prefix_code_bit_decoder_tb OK");
		else
			$display("prefix_code_bit_decoder_tb NOT OK");
		$finish;
	end

	initial begin
		#4000000;
		$display("prefix_code_bit_decoder_tb NOT OK");
		$finish;
	end
endmodule
